@@ sv/incubation_slot_timer_scheduler_core_assert.svh @@
// assertion macros used by the scheduler controller
`ifndef INCUBATION_SLOT_TIMER_SCHEDULER_CORE_ASSERT_SVH
`define INCUBATION_SLOT_TIMER_SCHEDULER_CORE_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define ISTS_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define ISTS_ASSERT(label, prop, msg) `ISTS_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

@@ sv/ists_pkg.sv @@
// ----------------------------------------------------------------------------
// ists_pkg
// Types and constants of the incubation slot timer scheduler.
// ----------------------------------------------------------------------------
package ists_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ACT_W      = 4;
  localparam int SLOT_IN_W  = 4;
  localparam int ORDER_W    = 32;
  localparam int DUR_W      = 16;
  localparam int GRACE_W    = 16;
  localparam int TIME_W     = 32;
  localparam int MASK_W     = 16;
  localparam int MASK_IDX_W = $clog2(MASK_W);
  localparam int LIM_W      = DUR_W + 1;
  localparam int KEY_W      = TIME_W + 2;

  localparam logic [GRACE_W-1:0] GRACE_RESET = GRACE_W'(60);
  localparam logic [SLOT_W-1:0]  LAST_IDX    = SLOT_W'(SLOT_COUNT - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK      = 4'd0,
    ACT_LOAD      = 4'd1,
    ACT_START     = 4'd2,
    ACT_CLEAR     = 4'd3,
    ACT_CLEAR_ALL = 4'd4,
    ACT_INACT     = 4'd5,
    ACT_QUERY     = 4'd6,
    ACT_PICK_FIN  = 4'd7,
    ACT_PICK_TO   = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    PH_UNUSED   = 2'd0,
    PH_RUNNING  = 2'd1,
    PH_FINISHED = 2'd2,
    PH_TIMEOUT  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

@@ sv/ists_ctrl.sv @@
// ----------------------------------------------------------------------------
// ists_ctrl
// Sequencer: takes a word, steps the datapath over its slots, then loads
// the result register when it is free.
// ----------------------------------------------------------------------------
`include "incubation_slot_timer_scheduler_core_assert.svh"

module ists_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ists_pkg::dp_cmd_t    cmd_o,
  input  ists_pkg::dp_status_t status_i
);
  import ists_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (status_i.last) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
    cmd_o.step    = (state_q == ST_SCAN);
    cmd_o.publish = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
    out_valid_d   = cmd_o.publish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ISTS_ASSERT(a_accept_starts_scan, cmd_o.capture |=> (state_q == ST_SCAN), "accepted word did not start its scan")
  `ISTS_ASSERT(a_last_step_done, cmd_o.step && status_i.last |=> (state_q == ST_DONE), "scan ran past its last slot")
  `ISTS_ASSERT(a_done_waits, (state_q == ST_DONE) && out_valid_q && !out_ready_i |=> (state_q == ST_DONE), "result dropped while output stalled")
  `ISTS_ASSERT(a_valid_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result word raised outside the done state")

endmodule

@@ sv/ists_dp.sv @@
// ----------------------------------------------------------------------------
// ists_dp
// Slot table, time counter and one shared slot update and compare unit
// that handles one slot per step.
// ----------------------------------------------------------------------------
module ists_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ists_pkg::dp_cmd_t                   cmd_i,
  output ists_pkg::dp_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [ists_pkg::GRACE_W-1:0]        cfg_wdata_i,
  input  logic [ists_pkg::ACT_W-1:0]          action_i,
  input  logic [ists_pkg::SLOT_IN_W-1:0]      slot_i,
  input  logic [ists_pkg::ORDER_W-1:0]        order_id_i,
  input  logic [ists_pkg::DUR_W-1:0]          duration_i,
  input  logic                                dilution_cup_i,
  output logic                                found_o,
  output logic [ists_pkg::SLOT_IN_W-1:0]      picked_slot_o,
  output logic [1:0]                          slot_phase_o,
  output logic [ists_pkg::MASK_W-1:0]         started_mask_o,
  output logic [ists_pkg::MASK_W-1:0]         timeout_mask_o
);
  import ists_pkg::*;

  // captured word
  logic [ACT_W-1:0]     act_q;
  logic [SLOT_IN_W-1:0] slot_q;
  logic [ORDER_W-1:0]   order_q;
  logic [DUR_W-1:0]     dur_q;
  logic                 dil_q;

  logic [GRACE_W-1:0]   grace_q;
  logic [TIME_W-1:0]    now_q;
  logic [SLOT_W-1:0]    idx_q;

  // slot table
  logic [ORDER_W-1:0] s_order_q [SLOT_COUNT];
  logic [DUR_W-1:0]   s_dur_q   [SLOT_COUNT];
  logic               s_dil_q   [SLOT_COUNT];
  logic               s_en_q    [SLOT_COUNT];
  logic               s_inact_q [SLOT_COUNT];
  phase_e             s_phase_q [SLOT_COUNT];
  logic [TIME_W-1:0]  s_start_q [SLOT_COUNT];

  // scan accumulators
  logic                    found_q, found_d;
  logic signed [KEY_W-1:0] best_q, best_d;
  logic [SLOT_W-1:0]       bi_q, bi_d;
  logic [MASK_W-1:0]       started_q, started_d;
  logic [MASK_W-1:0]       tmo_q, tmo_d;
  phase_e                  qphase_q, qphase_d;

  logic              scan_act, slot_ok, wr_en;
  logic [SLOT_W-1:0] sel_idx;
  logic [ORDER_W-1:0] cur_order, n_order;
  logic [DUR_W-1:0]   cur_dur, n_dur;
  logic               cur_dil, n_dil, cur_en, n_en, cur_inact, n_inact;
  phase_e             cur_phase, n_phase, ph;
  logic [TIME_W-1:0]  cur_start, n_start, elapsed;
  logic [LIM_W-1:0]   fin_lim;
  logic signed [KEY_W-1:0] left_v, key_v;
  logic [MASK_IDX_W-1:0]   mbit;
  logic               in_mask;
  phase_e             want;

  always_comb begin
    unique case (act_q)
      ACT_TICK, ACT_CLEAR_ALL, ACT_INACT, ACT_PICK_FIN, ACT_PICK_TO: scan_act = 1'b1;
      default: scan_act = 1'b0;
    endcase
  end

  assign slot_ok         = (32'(slot_q) < SLOT_COUNT);
  assign sel_idx         = scan_act ? idx_q : SLOT_W'(slot_q);
  assign status_o.last   = !scan_act || (idx_q == LAST_IDX);

  assign cur_order = s_order_q[sel_idx];
  assign cur_dur   = s_dur_q[sel_idx];
  assign cur_dil   = s_dil_q[sel_idx];
  assign cur_en    = s_en_q[sel_idx];
  assign cur_inact = s_inact_q[sel_idx];
  assign cur_phase = s_phase_q[sel_idx];
  assign cur_start = s_start_q[sel_idx];

  assign elapsed = now_q - cur_start;
  assign fin_lim = LIM_W'(cur_dur) + LIM_W'(grace_q);
  // deadline distance, negative once overdue
  assign left_v  = KEY_W'(fin_lim) - KEY_W'(elapsed);
  assign key_v   = (act_q == ACT_PICK_FIN) ? left_v : $signed(KEY_W'(cur_start));
  assign want    = (act_q == ACT_PICK_FIN) ? PH_FINISHED : PH_TIMEOUT;
  assign mbit    = MASK_IDX_W'(sel_idx);
  assign in_mask = (32'(sel_idx) < MASK_W);

  always_comb begin
    wr_en     = 1'b0;
    n_order   = cur_order;
    n_dur     = cur_dur;
    n_dil     = cur_dil;
    n_en      = cur_en;
    n_inact   = cur_inact;
    n_phase   = cur_phase;
    n_start   = cur_start;
    ph        = cur_phase;
    found_d   = found_q;
    best_d    = best_q;
    bi_d      = bi_q;
    started_d = started_q;
    tmo_d     = tmo_q;
    qphase_d  = qphase_q;
    if (cmd_i.step) begin
      unique case (act_q)
        ACT_TICK: begin
          if (cur_en) begin
            wr_en = 1'b1;
            if (cur_phase == PH_UNUSED) begin
              n_start = now_q;
              if (cur_dil) begin
                ph = PH_TIMEOUT;
              end else begin
                ph = PH_RUNNING;
                if (in_mask) started_d[mbit] = 1'b1;
              end
            end else if (cur_phase == PH_FINISHED && elapsed >= TIME_W'(fin_lim)) begin
              ph = PH_TIMEOUT;
              if (in_mask) tmo_d[mbit] = 1'b1;
            end else if (cur_phase == PH_RUNNING && elapsed >= TIME_W'(cur_dur)) begin
              ph = PH_FINISHED;
            end
            // inactive slots are forced out without a timeout report
            if (cur_inact) ph = PH_TIMEOUT;
            n_phase = ph;
          end
        end
        ACT_LOAD: begin
          if (slot_ok) begin
            wr_en   = 1'b1;
            n_order = order_q;
            n_dur   = dur_q;
            n_dil   = dil_q;
            n_en    = 1'b0;
            n_inact = 1'b0;
            n_phase = PH_UNUSED;
            n_start = '0;
          end
        end
        ACT_START: begin
          if (slot_ok) begin
            wr_en = 1'b1;
            n_en  = 1'b1;
          end
        end
        ACT_CLEAR, ACT_CLEAR_ALL: begin
          if (slot_ok || scan_act) begin
            wr_en   = 1'b1;
            n_order = '0;
            n_dur   = '0;
            n_dil   = 1'b0;
            n_en    = 1'b0;
            n_inact = 1'b0;
            n_phase = PH_UNUSED;
            n_start = '0;
          end
        end
        ACT_INACT: begin
          if (cur_order == order_q) begin
            wr_en   = 1'b1;
            n_inact = 1'b1;
          end
        end
        ACT_QUERY: begin
          qphase_d = slot_ok ? cur_phase : PH_UNUSED;
        end
        ACT_PICK_FIN, ACT_PICK_TO: begin
          // later slot wins a tie
          if (cur_phase == want && (!found_q || key_v <= best_q)) begin
            found_d = 1'b1;
            best_d  = key_v;
            bi_d    = sel_idx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q <= GRACE_RESET;
      now_q   <= '0;
      idx_q   <= '0;
      act_q   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        s_order_q[i] <= '0;
        s_dur_q[i]   <= '0;
        s_dil_q[i]   <= 1'b0;
        s_en_q[i]    <= 1'b0;
        s_inact_q[i] <= 1'b0;
        s_phase_q[i] <= PH_UNUSED;
        s_start_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) grace_q <= cfg_wdata_i;
      if (cmd_i.capture) begin
        act_q <= action_i;
        idx_q <= '0;
        // time advances before the slots are stepped
        if (action_i == ACT_TICK) now_q <= now_q + TIME_W'(1);
      end else if (cmd_i.step) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (wr_en) begin
        s_order_q[sel_idx] <= n_order;
        s_dur_q[sel_idx]   <= n_dur;
        s_dil_q[sel_idx]   <= n_dil;
        s_en_q[sel_idx]    <= n_en;
        s_inact_q[sel_idx] <= n_inact;
        s_phase_q[sel_idx] <= n_phase;
        s_start_q[sel_idx] <= n_start;
      end
    end
  end

  // word payload and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q    <= slot_i;
      order_q   <= order_id_i;
      dur_q     <= duration_i;
      dil_q     <= dilution_cup_i;
      found_q   <= 1'b0;
      best_q    <= '0;
      bi_q      <= '0;
      started_q <= '0;
      tmo_q     <= '0;
      qphase_q  <= PH_UNUSED;
    end else begin
      found_q   <= found_d;
      best_q    <= best_d;
      bi_q      <= bi_d;
      started_q <= started_d;
      tmo_q     <= tmo_d;
      qphase_q  <= qphase_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      found_o        <= 1'b0;
      picked_slot_o  <= '0;
      slot_phase_o   <= PH_UNUSED;
      started_mask_o <= started_q;
      timeout_mask_o <= tmo_q;
      if (act_q == ACT_QUERY) begin
        picked_slot_o <= slot_q;
        slot_phase_o  <= qphase_q;
      end else if ((act_q == ACT_PICK_FIN || act_q == ACT_PICK_TO) && found_q) begin
        found_o       <= 1'b1;
        picked_slot_o <= SLOT_IN_W'(bi_q);
        slot_phase_o  <= want;
      end
    end
  end

endmodule

@@ sv/incubation_slot_timer_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// incubation_slot_timer_scheduler_core
// Incubation slot table with one-second tick, slot commands and picks.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   action, slot, order_id,
//                                               duration, dilution_cup
//   out      output     out_valid_o/out_ready_i found, picked_slot, slot_phase,
//                                               started_mask, timeout_mask
//   cfg      input      cfg_we_i                cfg_wdata_i (grace seconds)
//
// A word for load, start, clear, query or an unknown code steps the shared slot
// unit once; tick, clear all, inactivate and both picks step it over all slots,
// one slot read, updated or compared per cycle.
// A new word is taken while the previous result waits in the output register.
// Reset empties the table, zeroes the time counter and sets grace to 60.
// ----------------------------------------------------------------------------
module incubation_slot_timer_scheduler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ists_pkg::ACT_W-1:0]     action_i,
  input  logic [ists_pkg::SLOT_IN_W-1:0] slot_i,
  input  logic [ists_pkg::ORDER_W-1:0]   order_id_i,
  input  logic [ists_pkg::DUR_W-1:0]     duration_i,
  input  logic                           dilution_cup_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic [ists_pkg::SLOT_IN_W-1:0] picked_slot_o,
  output logic [1:0]                     slot_phase_o,
  output logic [ists_pkg::MASK_W-1:0]    started_mask_o,
  output logic [ists_pkg::MASK_W-1:0]    timeout_mask_o,
  input  logic                           cfg_we_i,
  input  logic [ists_pkg::GRACE_W-1:0]   cfg_wdata_i
);
  import ists_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ists_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ists_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .slot_i         (slot_i),
    .order_id_i     (order_id_i),
    .duration_i     (duration_i),
    .dilution_cup_i (dilution_cup_i),
    .found_o        (found_o),
    .picked_slot_o  (picked_slot_o),
    .slot_phase_o   (slot_phase_o),
    .started_mask_o (started_mask_o),
    .timeout_mask_o (timeout_mask_o)
  );

endmodule

@@ dv/ists_sched_board_pkg.sv @@
// ----------------------------------------------------------------------------
// ists_sched_board_pkg
// Word and result types plus the slot schedule tracker: it mirrors the slot
// table, works out the outcome of every accepted word and checks the block's
// results against those outcomes in order.
// ----------------------------------------------------------------------------
package ists_sched_board_pkg;

  import ists_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [SLOT_IN_W-1:0] slot;
    logic [ORDER_W-1:0]   order_id;
    logic [DUR_W-1:0]     duration;
    logic                 dilution_cup;
  } sched_word_t;

  typedef struct packed {
    logic                 found;
    logic [SLOT_IN_W-1:0] picked_slot;
    phase_e               slot_phase;
    logic [MASK_W-1:0]    started_mask;
    logic [MASK_W-1:0]    timeout_mask;
  } slot_result_t;

  class slot_schedule_tracker;
    logic [GRACE_W-1:0] grace;
    logic [TIME_W-1:0]  now_s;
    logic [ORDER_W-1:0] order_tab [SLOT_COUNT];
    logic [DUR_W-1:0]   dur_tab   [SLOT_COUNT];
    logic               dil_tab   [SLOT_COUNT];
    logic               en_tab    [SLOT_COUNT];
    logic               inact_tab [SLOT_COUNT];
    phase_e             phase_tab [SLOT_COUNT];
    logic [TIME_W-1:0]  start_tab [SLOT_COUNT];
    slot_result_t       due_outcomes [$];
    int unsigned        mismatches;

    function new();
      grace      = GRACE_RESET;
      now_s      = '0;
      mismatches = 0;
      for (int s = 0; s < SLOT_COUNT; s++) clear_entry(s);
    endfunction

    function void clear_entry(int s);
      order_tab[s] = '0;
      dur_tab[s]   = '0;
      dil_tab[s]   = 1'b0;
      en_tab[s]    = 1'b0;
      inact_tab[s] = 1'b0;
      phase_tab[s] = PH_UNUSED;
      start_tab[s] = '0;
    endfunction

    function slot_result_t advance_table(sched_word_t w);
      slot_result_t      r;
      phase_e            ph;
      logic [TIME_W-1:0] elapsed;
      longint            left;
      longint            best_left;
      logic [TIME_W-1:0] best_start;
      bit                have;
      bit                slot_ok;
      r          = '0;
      have       = 1'b0;
      best_left  = 0;
      best_start = '0;
      slot_ok    = (32'(w.slot) < SLOT_COUNT);
      case (w.action)
        ACT_TICK: begin
          now_s = now_s + 1;
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (!en_tab[s]) continue;
            ph      = phase_tab[s];
            elapsed = now_s - start_tab[s];
            if (ph == PH_UNUSED) begin
              start_tab[s] = now_s;
              if (dil_tab[s]) begin
                ph = PH_TIMEOUT;
              end else begin
                ph = PH_RUNNING;
                if (s < MASK_W) r.started_mask[s] = 1'b1;
              end
            end else if (ph == PH_FINISHED &&
                         elapsed >= TIME_W'(dur_tab[s]) + TIME_W'(grace)) begin
              ph = PH_TIMEOUT;
              if (s < MASK_W) r.timeout_mask[s] = 1'b1;
            end else if (ph == PH_RUNNING && elapsed >= TIME_W'(dur_tab[s])) begin
              ph = PH_FINISHED;
            end
            // inactive slots are forced out silently
            if (inact_tab[s]) ph = PH_TIMEOUT;
            phase_tab[s] = ph;
          end
        end
        ACT_LOAD: begin
          if (slot_ok) begin
            clear_entry(w.slot);
            order_tab[w.slot] = w.order_id;
            dur_tab[w.slot]   = w.duration;
            dil_tab[w.slot]   = w.dilution_cup;
          end
        end
        ACT_START:     if (slot_ok) en_tab[w.slot] = 1'b1;
        ACT_CLEAR:     if (slot_ok) clear_entry(w.slot);
        ACT_CLEAR_ALL: for (int s = 0; s < SLOT_COUNT; s++) clear_entry(s);
        ACT_INACT: begin
          for (int s = 0; s < SLOT_COUNT; s++)
            if (order_tab[s] == w.order_id) inact_tab[s] = 1'b1;
        end
        ACT_QUERY: begin
          r.picked_slot = w.slot;
          r.slot_phase  = slot_ok ? phase_tab[w.slot] : PH_UNUSED;
        end
        ACT_PICK_FIN: begin
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (phase_tab[s] != PH_FINISHED) continue;
            elapsed = now_s - start_tab[s];
            left = longint'(dur_tab[s]) + longint'(grace) - longint'(elapsed);
            // ties go to the higher index
            if (!have || left <= best_left) begin
              have          = 1'b1;
              best_left     = left;
              r.picked_slot = SLOT_IN_W'(s);
            end
          end
          if (have) begin
            r.found      = 1'b1;
            r.slot_phase = PH_FINISHED;
          end
        end
        ACT_PICK_TO: begin
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (phase_tab[s] != PH_TIMEOUT) continue;
            if (!have || start_tab[s] <= best_start) begin
              have          = 1'b1;
              best_start    = start_tab[s];
              r.picked_slot = SLOT_IN_W'(s);
            end
          end
          if (have) begin
            r.found      = 1'b1;
            r.slot_phase = PH_TIMEOUT;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_word(sched_word_t w);
      due_outcomes.push_back(advance_table(w));
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      if (due_outcomes.size() == 0) begin
        $error("result word with no outcome pending");
        mismatches++;
        return;
      end
      want = due_outcomes.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        mismatches++;
      end
      if (got.picked_slot !== want.picked_slot) begin
        $error("picked_slot: expected %0d, actual %0d", want.picked_slot, got.picked_slot);
        mismatches++;
      end
      if (got.slot_phase !== want.slot_phase) begin
        $error("slot_phase: expected %0d, actual %0d", want.slot_phase, got.slot_phase);
        mismatches++;
      end
      if (got.started_mask !== want.started_mask) begin
        $error("started_mask: expected %h, actual %h", want.started_mask, got.started_mask);
        mismatches++;
      end
      if (got.timeout_mask !== want.timeout_mask) begin
        $error("timeout_mask: expected %h, actual %h", want.timeout_mask, got.timeout_mask);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ dv/incubation_slot_timer_scheduler_core_test.sv @@
// ----------------------------------------------------------------------------
// incubation_slot_timer_scheduler_core_test
// Drives load, start, clear, inactivate, query, pick and tick words into the
// scheduler core, first a directed walk through the slot phases and then
// random phases at several grace settings and idle patterns, and checks every
// result word against a tracked copy of the slot table.
// ----------------------------------------------------------------------------
module incubation_slot_timer_scheduler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ists_pkg::*;
  import ists_sched_board_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = 4'd9;
  localparam logic [ACT_W-1:0] ACT_LAST_UNUSED  = 4'd15;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ACT_W-1:0]     action_i;
  logic [SLOT_IN_W-1:0] slot_i;
  logic [ORDER_W-1:0]   order_id_i;
  logic [DUR_W-1:0]     duration_i;
  logic                 dilution_cup_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 found_o;
  logic [SLOT_IN_W-1:0] picked_slot_o;
  logic [1:0]           slot_phase_o;
  logic [MASK_W-1:0]    started_mask_o;
  logic [MASK_W-1:0]    timeout_mask_o;
  logic                 cfg_we_i;
  logic [GRACE_W-1:0]   cfg_wdata_i;

  slot_schedule_tracker tracker;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          cycle_count = 0;
  logic [ORDER_W-1:0]   order_pool [4];

  incubation_slot_timer_scheduler_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .slot_i         (slot_i),
    .order_id_i     (order_id_i),
    .duration_i     (duration_i),
    .dilution_cup_i (dilution_cup_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .picked_slot_o  (picked_slot_o),
    .slot_phase_o   (slot_phase_o),
    .started_mask_o (started_mask_o),
    .timeout_mask_o (timeout_mask_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    slot_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.found        = found_o;
      got.picked_slot  = picked_slot_o;
      got.slot_phase   = phase_e'(slot_phase_o);
      got.started_mask = started_mask_o;
      got.timeout_mask = timeout_mask_o;
      tracker.check_result(got);
    end
  end

  function automatic sched_word_t make_word(logic [ACT_W-1:0] act, logic [SLOT_IN_W-1:0] slot,
                                            logic [ORDER_W-1:0] order_id,
                                            logic [DUR_W-1:0] duration, logic dil);
    sched_word_t w;
    w.action       = act;
    w.slot         = slot;
    w.order_id     = order_id;
    w.duration     = duration;
    w.dilution_cup = dil;
    return w;
  endfunction

  function automatic logic [ORDER_W-1:0] pooled_order();
    int unsigned pick;
    pick = $urandom_range(7, 0);
    if (pick == 0) return '0;
    if (pick == 1) return $urandom;
    return order_pool[$urandom_range(3, 0)];
  endfunction

  // mostly short runs so slots reach finished and timed out
  function automatic logic [DUR_W-1:0] short_duration();
    int unsigned pick;
    pick = $urandom_range(19, 0);
    if (pick == 0) return '1;
    if (pick == 1) return DUR_W'($urandom);
    return DUR_W'($urandom_range(6, 0));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input sched_word_t w);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    action_i       <= w.action;
    slot_i         <= w.slot;
    order_id_i     <= w.order_id;
    duration_i     <= w.duration;
    dilution_cup_i <= w.dilution_cup;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.due_outcomes.size() != 0) @(negedge clk_i);
  endtask

  task automatic program_grace(input logic [GRACE_W-1:0] value);
    drain();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    tracker.grace  = value;
  endtask

  task automatic run_directed();
    send_word(make_word(ACT_QUERY, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_PICK_FIN, 4'd15, '1, '1, 1'b1));
    send_word(make_word(ACT_PICK_TO, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_LOAD, 4'd0, 32'hFFFF_FFFF, 16'd0, 1'b0));
    send_word(make_word(ACT_LOAD, 4'd15, 32'hA5A5_5A5A, 16'hFFFF, 1'b0));
    send_word(make_word(ACT_LOAD, 4'd7, 32'd77, 16'd2, 1'b1));
    send_word(make_word(ACT_LOAD, 4'd3, 32'd55, 16'd1, 1'b0));
    send_word(make_word(ACT_START, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_START, 4'd15, '0, '0, 1'b0));
    send_word(make_word(ACT_START, 4'd7, '0, '0, 1'b0));
    send_word(make_word(ACT_START, 4'd3, '0, '0, 1'b0));
    send_word(make_word(ACT_INACT, 4'd0, 32'd55, '0, 1'b0));
    // dilution cup times out unreported, inactive slot still shows as started
    send_word(make_word(ACT_TICK, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_TICK, 4'd15, '1, '1, 1'b1));
    send_word(make_word(ACT_QUERY, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_PICK_FIN, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_PICK_TO, 4'd0, '0, '0, 1'b0));
    // matches every cleared slot
    send_word(make_word(ACT_INACT, 4'd0, 32'd0, '0, 1'b0));
    send_word(make_word(ACT_LOAD, 4'd0, 32'd0, 16'd5, 1'b0));
    send_word(make_word(ACT_QUERY, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_CLEAR, 4'd15, '0, '0, 1'b0));
    send_word(make_word(ACT_FIRST_UNUSED, 4'd15, '1, '1, 1'b1));
    send_word(make_word(ACT_LAST_UNUSED, 4'd15, '1, '1, 1'b1));
    send_word(make_word(ACT_CLEAR_ALL, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_TICK, 4'd0, '0, '0, 1'b0));
    send_word(make_word(ACT_PICK_TO, 4'd0, '0, '0, 1'b0));
  endtask

  task automatic run_random(input int unsigned count);
    sched_word_t w;
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      w.slot         = SLOT_IN_W'($urandom);
      w.order_id     = $urandom;
      w.duration     = DUR_W'($urandom);
      w.dilution_cup = 1'($urandom);
      pick           = $urandom_range(99, 0);
      if (pick < 30) begin
        w.action = ACT_TICK;
      end else if (pick < 44) begin
        // load then start the same slot
        w.action       = ACT_LOAD;
        w.order_id     = pooled_order();
        w.duration     = short_duration();
        w.dilution_cup = ($urandom_range(4, 0) == 0);
        send_word(w);
        sent++;
        w.action = ACT_START;
      end else if (pick < 49) begin
        w.action   = ACT_LOAD;
        w.order_id = pooled_order();
        w.duration = short_duration();
      end else if (pick < 54) begin
        w.action = ACT_START;
      end else if (pick < 63) begin
        w.action = ACT_QUERY;
      end else if (pick < 71) begin
        w.action = ACT_PICK_FIN;
      end else if (pick < 79) begin
        w.action = ACT_PICK_TO;
      end else if (pick < 85) begin
        w.action = ACT_CLEAR;
      end else if (pick < 91) begin
        w.action   = ACT_INACT;
        w.order_id = pooled_order();
      end else if (pick < 93) begin
        w.action = ACT_CLEAR_ALL;
      end else if (pick < 96) begin
        w.action = ACT_W'($urandom_range(ACT_LAST_UNUSED, ACT_FIRST_UNUSED));
      end else begin
        w.action = ACT_TICK;
      end
      send_word(w);
      sent++;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = '0;
    slot_i         = '0;
    order_id_i     = '0;
    duration_i     = '0;
    dilution_cup_i = 1'b0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tracker        = new();
    for (int i = 0; i < 4; i++) order_pool[i] = $urandom;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random(220);

    program_grace(16'd0);
    send_idle_pct = 56;
    run_random(220);

    program_grace(16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    run_random(220);

    program_grace(16'd2);
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    run_random(220);

    program_grace(GRACE_W'($urandom_range(5, 1)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(220);

    drain();
    // give stray result words time to show after the last scan
    repeat (2 * SLOT_COUNT) @(negedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
